@@ sv/assert_macros.svh @@
// Assertion macros shared by the clock replacement block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define CPR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("cpr assertion failed");
// Check that a condition never holds outside reset.
`define CPR_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("cpr forbidden condition");
`else
`define CPR_ASSERT(lbl, clk, rst, prop)
`define CPR_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ sv/cpr_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the
// clock replacement MMU. No dependencies.
`default_nettype none
package cpr_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int MAX_PROCS  = 8;
  localparam int MAX_PAGES  = 64;

  localparam int FRAME_W  = $clog2(NUM_FRAMES);
  localparam int NACT_W   = $clog2(NUM_FRAMES + 1);
  localparam int PID_W    = $clog2(MAX_PROCS);
  localparam int PAGE_W   = $clog2(MAX_PAGES);
  localparam int PAGES_W  = $clog2(MAX_PAGES + 1);
  localparam int PT_AW    = PID_W + PAGE_W;
  localparam int PT_DEPTH = MAX_PROCS * MAX_PAGES;

  localparam int PK_W       = 11;
  localparam int AB_W       = 6;
  localparam int AF_W       = 5;
  localparam int CMD_W      = 2;
  localparam int SIZE_W     = 16;
  localparam int ADDR_W     = 24;
  localparam int STATUS_W   = 3;
  localparam int PNUM_W     = 16;
  localparam int EVPAGE_W   = 6;
  localparam int SUSP_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // address * bits / 8 / 1024 is a product followed by a 13-bit shift
  localparam int PROD_W     = ADDR_W + AB_W;
  localparam int KB_SHIFT   = 13;
  localparam int DIV_W      = PROD_W - KB_SHIFT;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CREATED   = 3'd0,
    ST_HIT       = 3'd1,
    ST_FAULT_NEW = 3'd2,
    ST_FAULT_DSK = 3'd3,
    ST_SUSPENDED = 3'd4,
    ST_UNKNOWN   = 3'd5,
    ST_DUPLICATE = 3'd6
  } status_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_KB       = 2'd0,
    CFG_ADDR_BITS     = 2'd1,
    CFG_ACTIVE_FRAMES = 2'd2
  } cfg_e_t;

  // One datapath operation per cycle, issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_MUL,
    OP_DIV_CREATE,
    OP_DIV_ACCESS,
    OP_DIV_STEP,
    OP_CLEAR,
    OP_CREATE_DONE,
    OP_SUSPEND,
    OP_PT_READ,
    OP_HIT,
    OP_HAND_INIT,
    OP_SCAN_STEP,
    OP_EVICT,
    OP_MAP,
    OP_RESULT_DUP,
    OP_OUT_LOAD
  } op_e_t;

  typedef struct packed {
    logic                 mapped;
    logic                 resident;
    logic [FRAME_W-1:0]   frame;
  } pt_entry_t;

  typedef struct packed {
    op_e_t op;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_e_t command;
    logic   live;
    logic   div_done;
    logic   page_oob;
    logic   clear_done;
    logic   resident;
    logic   ref_at_hand;
    logic   out_free;
  } ctl_stat_t;

endpackage
`default_nettype wire

@@ sv/cpr_ctrl.sv @@
// Sequencing controller for the clock replacement MMU.
// Uses cpr_pkg types; drives the datapath through ctl_cmd_t.
`default_nettype none
module cpr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire cpr_pkg::ctl_stat_t stat,
  output cpr_pkg::ctl_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL, S_DIV, S_CLEAR, S_CREATE, S_SUSP,
    S_PTRD, S_LOOKUP, S_SCAN, S_EVICT, S_MAP, S_DONE
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  // next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op     = cpr_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.op     = cpr_pkg::OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        unique case (stat.command) inside
          cpr_pkg::CMD_CREATE: begin
            if (stat.live) begin
              cmd.op = cpr_pkg::OP_RESULT_DUP;
            end else begin
              cmd.op     = cpr_pkg::OP_DIV_CREATE;
              state_next = S_DIV;
            end
          end
          cpr_pkg::CMD_READ, cpr_pkg::CMD_WRITE: begin
            if (stat.live) begin
              cmd.op     = cpr_pkg::OP_MUL;
              state_next = S_MUL;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_MUL: begin
        cmd.op     = cpr_pkg::OP_DIV_ACCESS;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!stat.div_done) begin
          cmd.op = cpr_pkg::OP_DIV_STEP;
        end else if (stat.command == cpr_pkg::CMD_CREATE) begin
          state_next = S_CLEAR;
        end else if (stat.page_oob) begin
          state_next = S_SUSP;
        end else begin
          state_next = S_PTRD;
        end
      end
      S_CLEAR: begin
        if (!stat.clear_done) cmd.op = cpr_pkg::OP_CLEAR;
        else state_next = S_CREATE;
      end
      S_CREATE: begin
        cmd.op     = cpr_pkg::OP_CREATE_DONE;
        state_next = S_DONE;
      end
      S_SUSP: begin
        cmd.op     = cpr_pkg::OP_SUSPEND;
        state_next = S_DONE;
      end
      S_PTRD: begin
        cmd.op     = cpr_pkg::OP_PT_READ;
        state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (stat.resident) begin
          cmd.op     = cpr_pkg::OP_HIT;
          state_next = S_DONE;
        end else begin
          cmd.op     = cpr_pkg::OP_HAND_INIT;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.ref_at_hand) cmd.op = cpr_pkg::OP_SCAN_STEP;
        else state_next = S_EVICT;
      end
      S_EVICT: begin
        cmd.op     = cpr_pkg::OP_EVICT;
        state_next = S_MAP;
      end
      S_MAP: begin
        cmd.op     = cpr_pkg::OP_MAP;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = cpr_pkg::OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/cpr_dp.sv @@
// Datapath of the clock replacement MMU: config, process table, page table
// memory, frame table, clock hand, shared divider and result word.
// Uses cpr_pkg and assert_macros.svh; driven by cpr_ctrl.
`default_nettype none
`include "assert_macros.svh"
module cpr_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [cpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cpr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [cpr_pkg::CMD_W-1:0]        command,
  input  wire logic [cpr_pkg::PID_W-1:0]        process_id,
  input  wire logic [cpr_pkg::SIZE_W-1:0]       size_kb,
  input  wire logic [cpr_pkg::ADDR_W-1:0]       address,
  input  wire cpr_pkg::ctl_cmd_t                cmd,
  output cpr_pkg::ctl_stat_t                    stat,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output logic [cpr_pkg::STATUS_W-1:0]          status,
  output logic [cpr_pkg::PNUM_W-1:0]            page_number,
  output logic [cpr_pkg::FRAME_W-1:0]           frame,
  output logic                                  evicted_valid,
  output logic [cpr_pkg::PID_W-1:0]             evicted_process,
  output logic [cpr_pkg::EVPAGE_W-1:0]          evicted_page,
  output logic [cpr_pkg::SUSP_W-1:0]            suspended_count
);

  // configuration
  logic [cpr_pkg::PK_W-1:0]  page_kb;
  logic [cpr_pkg::AB_W-1:0]  address_bits;
  logic [cpr_pkg::AF_W-1:0]  active_frames;

  // latched word
  logic [cpr_pkg::CMD_W-1:0]  cmd_q;
  logic [cpr_pkg::PID_W-1:0]  pid;
  logic [cpr_pkg::SIZE_W-1:0] size_q;
  logic [cpr_pkg::ADDR_W-1:0] addr_q;
  logic [cpr_pkg::PROD_W-1:0] prod;

  // process slots
  logic                          live  [cpr_pkg::MAX_PROCS];
  logic [cpr_pkg::PAGES_W-1:0]   pages [cpr_pkg::MAX_PROCS];

  // frame table
  logic                          frame_owned [cpr_pkg::NUM_FRAMES];
  logic [cpr_pkg::PID_W-1:0]     frame_owner [cpr_pkg::NUM_FRAMES];
  logic [cpr_pkg::PAGE_W-1:0]    frame_page  [cpr_pkg::NUM_FRAMES];
  logic                          frame_ref   [cpr_pkg::NUM_FRAMES];
  logic [cpr_pkg::FRAME_W-1:0]   hand;
  logic [cpr_pkg::SUSP_W-1:0]    suspensions;

  // page table memory, one read and one write port
  cpr_pkg::pt_entry_t            pt_mem [cpr_pkg::PT_DEPTH];
  cpr_pkg::pt_entry_t            pt_q;
  cpr_pkg::pt_entry_t            pt_wdata;
  logic                          pt_we;
  logic [cpr_pkg::PT_AW-1:0]     pt_waddr;
  logic [cpr_pkg::PT_AW-1:0]     pt_raddr;
  logic [cpr_pkg::PAGE_W:0]      clr_cnt;

  // divider
  logic [cpr_pkg::PK_W-1:0]      div_rem;
  logic [cpr_pkg::DIV_W-1:0]     div_q;
  logic [cpr_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [cpr_pkg::PK_W:0]        div_t;
  logic                          div_bit;
  logic [cpr_pkg::PK_W-1:0]      pk;

  // result word under construction
  logic [cpr_pkg::STATUS_W-1:0]  res_status;
  logic [cpr_pkg::PNUM_W-1:0]    res_pnum;
  logic [cpr_pkg::FRAME_W-1:0]   res_frame;
  logic                          res_ev;
  logic [cpr_pkg::PID_W-1:0]     res_evp;
  logic [cpr_pkg::PAGE_W-1:0]    res_evg;

  logic [cpr_pkg::NACT_W-1:0]    n_act;
  logic [cpr_pkg::NACT_W-1:0]    hand_inc;
  logic [cpr_pkg::FRAME_W-1:0]   hand_wrap;
  logic [cpr_pkg::PAGES_W-1:0]   new_pages;
  logic [cpr_pkg::PNUM_W-1:0]    pnum_sat;

  // derived values
  assign pk = (page_kb == '0) ? cpr_pkg::PK_W'(1) : page_kb;

  always_comb begin
    if (active_frames == '0) n_act = cpr_pkg::NACT_W'(1);
    else if (cpr_pkg::NACT_W'(active_frames) > cpr_pkg::NACT_W'(cpr_pkg::NUM_FRAMES))
      n_act = cpr_pkg::NACT_W'(cpr_pkg::NUM_FRAMES);
    else n_act = cpr_pkg::NACT_W'(active_frames);
  end

  assign hand_inc  = cpr_pkg::NACT_W'(hand) + cpr_pkg::NACT_W'(1);
  assign hand_wrap = (hand_inc == n_act) ? '0 : hand_inc[cpr_pkg::FRAME_W-1:0];

  assign new_pages = (div_q >= cpr_pkg::DIV_W'(cpr_pkg::MAX_PAGES))
                   ? cpr_pkg::PAGES_W'(cpr_pkg::MAX_PAGES)
                   : div_q[cpr_pkg::PAGES_W-1:0];
  assign pnum_sat  = (|div_q[cpr_pkg::DIV_W-1:cpr_pkg::PNUM_W])
                   ? '1 : div_q[cpr_pkg::PNUM_W-1:0];

  // one restoring division step
  assign div_t   = {div_rem, div_q[cpr_pkg::DIV_W-1]};
  assign div_bit = (div_t >= {1'b0, pk});

  // status to controller
  always_comb begin
    stat.command     = cpr_pkg::cmd_e_t'(cmd_q);
    stat.live        = live[pid];
    stat.div_done    = (div_cnt == '0);
    stat.page_oob    = (div_q >= cpr_pkg::DIV_W'(pages[pid]));
    stat.clear_done  = clr_cnt[cpr_pkg::PAGE_W];
    stat.resident    = pt_q.resident;
    stat.ref_at_hand = frame_ref[hand];
    stat.out_free    = !result_valid || result_ready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      page_kb       <= cpr_pkg::PK_W'(4);
      address_bits  <= cpr_pkg::AB_W'(16);
      active_frames <= cpr_pkg::AF_W'(16);
    end else if (cfg_valid) begin
      unique case (cpr_pkg::cfg_e_t'(cfg_index))
        cpr_pkg::CFG_PAGE_KB:       page_kb       <= cfg_data[cpr_pkg::PK_W-1:0];
        cpr_pkg::CFG_ADDR_BITS:     address_bits  <= cfg_data[cpr_pkg::AB_W-1:0];
        cpr_pkg::CFG_ACTIVE_FRAMES: active_frames <= cfg_data[cpr_pkg::AF_W-1:0];
        default: ;
      endcase
    end
  end

  // input latch, product and divider
  always_ff @(posedge clk) begin
    if (cmd.op == cpr_pkg::OP_LATCH) begin
      cmd_q  <= command;
      pid    <= process_id;
      size_q <= size_kb;
      addr_q <= address;
    end
    if (cmd.op == cpr_pkg::OP_MUL) begin
      prod <= cpr_pkg::PROD_W'(addr_q) * cpr_pkg::PROD_W'(address_bits);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
      clr_cnt <= '0;
    end else begin
      unique case (cmd.op)
        cpr_pkg::OP_DIV_CREATE: begin
          div_rem <= '0;
          div_q   <= cpr_pkg::DIV_W'(size_q) + cpr_pkg::DIV_W'(pk) - cpr_pkg::DIV_W'(1);
          div_cnt <= cpr_pkg::DIV_CNT_W'(cpr_pkg::DIV_W);
          clr_cnt <= '0;
        end
        cpr_pkg::OP_DIV_ACCESS: begin
          div_rem <= '0;
          div_q   <= prod[cpr_pkg::PROD_W-1:cpr_pkg::KB_SHIFT];
          div_cnt <= cpr_pkg::DIV_CNT_W'(cpr_pkg::DIV_W);
        end
        cpr_pkg::OP_DIV_STEP: begin
          div_rem <= div_bit ? cpr_pkg::PK_W'(div_t - {1'b0, pk})
                             : div_t[cpr_pkg::PK_W-1:0];
          div_q   <= {div_q[cpr_pkg::DIV_W-2:0], div_bit};
          div_cnt <= div_cnt - cpr_pkg::DIV_CNT_W'(1);
        end
        cpr_pkg::OP_CLEAR: clr_cnt <= clr_cnt + (cpr_pkg::PAGE_W+1)'(1);
        default: ;
      endcase
    end
  end

  // page table write select
  assign pt_raddr = {pid, div_q[cpr_pkg::PAGE_W-1:0]};

  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = {pid, clr_cnt[cpr_pkg::PAGE_W-1:0]};
    pt_wdata = '0;
    case (cmd.op)
      cpr_pkg::OP_CLEAR: pt_we = 1'b1;
      cpr_pkg::OP_EVICT: begin
        pt_we    = frame_owned[hand];
        pt_waddr = {frame_owner[hand], frame_page[hand]};
        pt_wdata = '{mapped: 1'b1, resident: 1'b0, frame: hand};
      end
      cpr_pkg::OP_MAP: begin
        pt_we    = 1'b1;
        pt_waddr = pt_raddr;
        pt_wdata = '{mapped: 1'b1, resident: 1'b1, frame: hand};
      end
      default: ;
    endcase
  end

  // page table memory; a slot is swept clean on create before any access
  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    if (cmd.op == cpr_pkg::OP_PT_READ) pt_q <= pt_mem[pt_raddr];
  end

  // process slots, frame table, clock hand, suspension count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cpr_pkg::MAX_PROCS; i++) begin
        live[i]  <= 1'b0;
        pages[i] <= '0;
      end
      for (int f = 0; f < cpr_pkg::NUM_FRAMES; f++) begin
        frame_owned[f] <= 1'b0;
        frame_owner[f] <= '0;
        frame_page[f]  <= '0;
        frame_ref[f]   <= 1'b0;
      end
      hand        <= '0;
      suspensions <= '0;
    end else begin
      case (cmd.op)
        cpr_pkg::OP_CREATE_DONE: begin
          live[pid]  <= 1'b1;
          pages[pid] <= new_pages;
        end
        cpr_pkg::OP_SUSPEND: begin
          for (int f = 0; f < cpr_pkg::NUM_FRAMES; f++) begin
            if (frame_owned[f] && frame_owner[f] == pid) begin
              frame_owned[f] <= 1'b0;
              frame_owner[f] <= '0;
              frame_page[f]  <= '0;
              frame_ref[f]   <= 1'b0;
            end
          end
          live[pid]  <= 1'b0;
          pages[pid] <= '0;
          if (suspensions != '1) suspensions <= suspensions + cpr_pkg::SUSP_W'(1);
        end
        cpr_pkg::OP_HIT: frame_ref[pt_q.frame] <= 1'b1;
        cpr_pkg::OP_HAND_INIT: begin
          if (cpr_pkg::NACT_W'(hand) >= n_act) hand <= '0;
        end
        cpr_pkg::OP_SCAN_STEP: begin
          frame_ref[hand] <= 1'b0;
          hand            <= hand_wrap;
        end
        cpr_pkg::OP_MAP: begin
          frame_owned[hand] <= 1'b1;
          frame_owner[hand] <= pid;
          frame_page[hand]  <= div_q[cpr_pkg::PAGE_W-1:0];
          hand              <= hand_wrap;
        end
        default: ;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    case (cmd.op)
      cpr_pkg::OP_LATCH: begin
        res_status <= cpr_pkg::ST_UNKNOWN;
        res_pnum   <= '0;
        res_frame  <= '0;
        res_ev     <= 1'b0;
        res_evp    <= '0;
        res_evg    <= '0;
      end
      cpr_pkg::OP_RESULT_DUP: res_status <= cpr_pkg::ST_DUPLICATE;
      cpr_pkg::OP_CREATE_DONE: begin
        res_status <= cpr_pkg::ST_CREATED;
        res_pnum   <= cpr_pkg::PNUM_W'(new_pages);
      end
      cpr_pkg::OP_SUSPEND: begin
        res_status <= cpr_pkg::ST_SUSPENDED;
        res_pnum   <= pnum_sat;
      end
      cpr_pkg::OP_HIT: begin
        res_status <= cpr_pkg::ST_HIT;
        res_pnum   <= pnum_sat;
        res_frame  <= pt_q.frame;
      end
      cpr_pkg::OP_EVICT: begin
        res_ev  <= frame_owned[hand];
        res_evp <= frame_owned[hand] ? frame_owner[hand] : '0;
        res_evg <= frame_owned[hand] ? frame_page[hand] : '0;
      end
      cpr_pkg::OP_MAP: begin
        res_status <= pt_q.mapped ? cpr_pkg::ST_FAULT_DSK : cpr_pkg::ST_FAULT_NEW;
        res_pnum   <= pnum_sat;
        res_frame  <= hand;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.op == cpr_pkg::OP_OUT_LOAD) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == cpr_pkg::OP_OUT_LOAD) begin
      status          <= res_status;
      page_number     <= res_pnum;
      frame           <= res_frame;
      evicted_valid   <= res_ev;
      evicted_process <= res_evp;
      evicted_page    <= cpr_pkg::EVPAGE_W'(res_evg);
      suspended_count <= suspensions;
    end
  end

  `CPR_NEVER(a_div_overrun, clk, rst, cmd.op == cpr_pkg::OP_DIV_STEP && div_cnt == '0)
  `CPR_ASSERT(a_valid_from_load, clk, rst, $rose(result_valid) |-> $past(cmd.op == cpr_pkg::OP_OUT_LOAD))
  `CPR_ASSERT(a_map_live, clk, rst, cmd.op == cpr_pkg::OP_MAP |-> live[pid])
  `CPR_ASSERT(a_load_free, clk, rst, cmd.op == cpr_pkg::OP_OUT_LOAD |-> (!result_valid || result_ready))

endmodule
`default_nettype wire

@@ sv/clock_page_replacement_mmu_core.sv @@
// Top level of the clock (second-chance) page replacement MMU.
// Instantiates cpr_ctrl and cpr_dp; uses cpr_pkg.
//
// One word in, one result word out. Items are handled one at a time: a
// create runs latch, decode, the 17-step divider and a finishing step,
// a sweep of the process's 64-entry page table row and a finishing step,
// update and result load. An access runs a multiply, the 17-step divider
// and, unless it suspends, a page table read; a fault adds a clock scan
// that clears reference bits, at most the active frame count (taken as
// 1..16), then evict and map. Unknown and duplicate requests go straight
// to the result load. The result sits in an output register, so the next
// word is taken while a result waits; the item after that stalls in its
// last cycle until the waiting result is taken. Configuration writes are
// always accepted and must only be made while the block is idle.
`default_nettype none
module clock_page_replacement_mmu_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cpr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             item_valid,
  output logic                                  item_ready,
  input  wire logic [cpr_pkg::CMD_W-1:0]        command,
  input  wire logic [cpr_pkg::PID_W-1:0]        process_id,
  input  wire logic [cpr_pkg::SIZE_W-1:0]       size_kb,
  input  wire logic [cpr_pkg::ADDR_W-1:0]       address,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output logic [cpr_pkg::STATUS_W-1:0]          status,
  output logic [cpr_pkg::PNUM_W-1:0]            page_number,
  output logic [cpr_pkg::FRAME_W-1:0]           frame,
  output logic                                  evicted_valid,
  output logic [cpr_pkg::PID_W-1:0]             evicted_process,
  output logic [cpr_pkg::EVPAGE_W-1:0]          evicted_page,
  output logic [cpr_pkg::SUSP_W-1:0]            suspended_count
);

  cpr_pkg::ctl_cmd_t  cmd;
  cpr_pkg::ctl_stat_t stat;

  assign cfg_ready = 1'b1;

  cpr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  cpr_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .command         (command),
    .process_id      (process_id),
    .size_kb         (size_kb),
    .address         (address),
    .cmd             (cmd),
    .stat            (stat),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .status          (status),
    .page_number     (page_number),
    .frame           (frame),
    .evicted_valid   (evicted_valid),
    .evicted_process (evicted_process),
    .evicted_page    (evicted_page),
    .suspended_count (suspended_count)
  );

endmodule
`default_nettype wire

@@ bench/tb_clock_page_replacement_mmu_core.sv @@
// Self-checking bench for clock_page_replacement_mmu_core: a behavioral page
// table / clock replacement predictor checks every result word in order.
// Depends on cpr_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_clock_page_replacement_mmu_core;

  typedef struct packed {
    logic [cpr_pkg::CMD_W-1:0]  cmd;
    logic [cpr_pkg::PID_W-1:0]  pid;
    logic [cpr_pkg::SIZE_W-1:0] size;
    logic [cpr_pkg::ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [cpr_pkg::STATUS_W-1:0] st;
    logic [cpr_pkg::PNUM_W-1:0]   pnum;
    logic [cpr_pkg::FRAME_W-1:0]  frm;
    logic                         ev;
    logic [cpr_pkg::PID_W-1:0]    evp;
    logic [cpr_pkg::EVPAGE_W-1:0] evg;
    logic [cpr_pkg::SUSP_W-1:0]   susp;
  } resp_t;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [cpr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cpr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic item_valid = 0, item_ready;
  logic [cpr_pkg::CMD_W-1:0] command = '0;
  logic [cpr_pkg::PID_W-1:0] process_id = '0;
  logic [cpr_pkg::SIZE_W-1:0] size_kb = '0;
  logic [cpr_pkg::ADDR_W-1:0] address = '0;
  logic result_valid, result_ready = 0;
  logic [cpr_pkg::STATUS_W-1:0] status;
  logic [cpr_pkg::PNUM_W-1:0] page_number;
  logic [cpr_pkg::FRAME_W-1:0] frame;
  logic evicted_valid;
  logic [cpr_pkg::PID_W-1:0] evicted_process;
  logic [cpr_pkg::EVPAGE_W-1:0] evicted_page;
  logic [cpr_pkg::SUSP_W-1:0] suspended_count;

  clock_page_replacement_mmu_core i_dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor state
  int unsigned pg_kb, addr_bits, act_frames;
  bit proc_live[cpr_pkg::MAX_PROCS];
  int unsigned proc_pages[cpr_pkg::MAX_PROCS];
  int pt_frame[cpr_pkg::MAX_PROCS][cpr_pkg::MAX_PAGES];   // -1 unmapped
  bit pt_res[cpr_pkg::MAX_PROCS][cpr_pkg::MAX_PAGES];
  bit fr_owned[cpr_pkg::NUM_FRAMES];
  int unsigned fr_owner[cpr_pkg::NUM_FRAMES], fr_page[cpr_pkg::NUM_FRAMES];
  bit fr_ref[cpr_pkg::NUM_FRAMES];
  int unsigned hand, susp_cnt;

  req_t  pending_words[$];
  resp_t expected_results[$];
  int    errors = 0, stall_cycles = 0;
  bit    took = 0;

  function automatic void unmap_process(int unsigned p);
    for (int i = 0; i < cpr_pkg::MAX_PAGES; i++) begin
      pt_frame[p][i] = -1;
      pt_res[p][i] = 0;
    end
  endfunction

  function automatic void reset_mmu_model();
    pg_kb = 4; addr_bits = 16; act_frames = 16; hand = 0; susp_cnt = 0;
    for (int p = 0; p < cpr_pkg::MAX_PROCS; p++) begin
      proc_live[p] = 0; proc_pages[p] = 0; unmap_process(p);
    end
    for (int f = 0; f < cpr_pkg::NUM_FRAMES; f++) begin
      fr_owned[f] = 0; fr_owner[f] = 0; fr_page[f] = 0; fr_ref[f] = 0;
    end
  endfunction

  function automatic resp_t translate(req_t r);
    resp_t o;
    longint unsigned pk, n, pg;
    int unsigned h, na;
    pk = (pg_kb == 0) ? 1 : pg_kb;
    o = '{cpr_pkg::ST_UNKNOWN, 0, 0, 0, 0, 0, 0};
    if (r.cmd == cpr_pkg::CMD_CREATE) begin
      if (proc_live[r.pid]) o.st = cpr_pkg::ST_DUPLICATE;
      else begin
        n = (64'(r.size) + pk - 1) / pk;
        if (n > cpr_pkg::MAX_PAGES) n = cpr_pkg::MAX_PAGES;
        proc_live[r.pid] = 1; proc_pages[r.pid] = 32'(n);
        unmap_process(r.pid);
        o.st = cpr_pkg::ST_CREATED; o.pnum = 16'(n);
      end
    end else if (r.cmd != cpr_pkg::CMD_NONE && proc_live[r.pid]) begin
      pg = 64'(r.addr) * addr_bits / 8 / 1024 / pk;
      o.pnum = (pg > 65535) ? 16'hFFFF : pg[15:0];
      if (pg >= proc_pages[r.pid]) begin
        // out of bounds: suspend and free its frames
        for (int f = 0; f < cpr_pkg::NUM_FRAMES; f++)
          if (fr_owned[f] && fr_owner[f] == r.pid) begin
            fr_owned[f] = 0; fr_owner[f] = 0; fr_page[f] = 0; fr_ref[f] = 0;
          end
        unmap_process(r.pid);
        proc_live[r.pid] = 0; proc_pages[r.pid] = 0;
        if (susp_cnt < 255) susp_cnt++;
        o.st = cpr_pkg::ST_SUSPENDED;
      end else if (pt_res[r.pid][pg] && pt_frame[r.pid][pg] >= 0) begin
        fr_ref[pt_frame[r.pid][pg]] = 1;
        o.frm = 4'(pt_frame[r.pid][pg]);
        o.st = cpr_pkg::ST_HIT;
      end else begin
        // clock scan: clear ref bits until a clear frame
        na = (act_frames == 0) ? 1 :
             (act_frames > cpr_pkg::NUM_FRAMES ? cpr_pkg::NUM_FRAMES : act_frames);
        h = (hand >= na) ? 0 : hand;
        while (fr_ref[h]) begin
          fr_ref[h] = 0; h = (h + 1) % na;
        end
        if (fr_owned[h]) begin
          pt_res[fr_owner[h]][fr_page[h]] = 0;
          o.ev = 1; o.evp = 3'(fr_owner[h]); o.evg = 6'(fr_page[h]);
        end
        o.st = (pt_frame[r.pid][pg] != -1) ? cpr_pkg::ST_FAULT_DSK : cpr_pkg::ST_FAULT_NEW;
        pt_frame[r.pid][pg] = h; pt_res[r.pid][pg] = 1;
        fr_owned[h] = 1; fr_owner[h] = r.pid; fr_page[h] = 32'(pg); fr_ref[h] = 0;
        o.frm = 4'(h);
        hand = (h + 1) % na;
      end
    end
    o.susp = 8'(susp_cnt);
    return o;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver: one word from the queue, gaps between words; random result stalls
  int unsigned drv_gap = 0, rdy_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (item_valid && !took) begin
        // hold until accepted
      end else begin
        if (took) begin
          took = 0;
          drv_gap = gap_len();
        end
        if (drv_gap > 0) begin
          drv_gap--; item_valid <= 0;
        end else if (pending_words.size() > 0) begin
          item_valid <= 1;
          command <= pending_words[0].cmd; process_id <= pending_words[0].pid;
          size_kb <= pending_words[0].size; address <= pending_words[0].addr;
        end else item_valid <= 0;
      end
      if (rdy_gap > 0) begin
        rdy_gap--; result_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
        rdy_gap = gap_len(); result_ready <= 1'b0;
      end else result_ready <= 1'b1;
    end
  end

  // predict on acceptance, check results
  always @(posedge clk) begin
    if (!rst) begin
      stall_cycles++;
      if (item_valid && item_ready) begin
        req_t r;
        r.cmd = command; r.pid = process_id; r.size = size_kb; r.addr = address;
        expected_results.push_back(translate(r));
        void'(pending_words.pop_front());
        took = 1;
        stall_cycles = 0;
      end
      if (cfg_valid && cfg_ready) stall_cycles = 0;
      if (result_valid && result_ready) begin
        resp_t e, a;
        stall_cycles = 0;
        a = '{status, page_number, frame, evicted_valid, evicted_process,
              evicted_page, suspended_count};
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result word status=%0d", $time, status);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (a != e) begin
            $display("%0t mismatch exp st=%0d pg=%0d fr=%0d ev=%0d/%0d/%0d sc=%0d",
                     $time, e.st, e.pnum, e.frm, e.ev, e.evp, e.evg, e.susp);
            $display("%0t          act st=%0d pg=%0d fr=%0d ev=%0d/%0d/%0d sc=%0d",
                     $time, a.st, a.pnum, a.frm, a.ev, a.evp, a.evg, a.susp);
            errors++;
          end
        end
      end
      if (stall_cycles > 20000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic push_word(logic [1:0] c, logic [2:0] p, logic [15:0] s,
                           logic [23:0] a);
    req_t r;
    r.cmd = c; r.pid = p; r.size = s; r.addr = a;
    pending_words.push_back(r);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || item_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(cpr_pkg::cfg_e_t idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= 11'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    case (idx)
      cpr_pkg::CFG_PAGE_KB:   pg_kb = val & 11'h7FF;
      cpr_pkg::CFG_ADDR_BITS: addr_bits = val & 6'h3F;
      default:                act_frames = val & 5'h1F;
    endcase
  endtask

  // random phase: mostly reads and writes from random processes, mixed with creates and unknown words
  task automatic random_phase(int cnt);
    for (int i = 0; i < cnt; i++) begin
      int unsigned k = $urandom_range(0, 99);
      logic [2:0] p = 3'($urandom_range(0, 7));
      if (k < 10) push_word(cpr_pkg::CMD_CREATE, p, 16'($urandom_range(0, 40)), 24'($urandom));
      else if (k < 12) push_word(cpr_pkg::CMD_CREATE, p, 16'($urandom), 24'($urandom));
      else if (k < 14) push_word(cpr_pkg::CMD_NONE, p, 16'($urandom), 24'($urandom));
      else if (k < 17) push_word(2'($urandom_range(1, 2)), p, 16'($urandom), 24'($urandom));
      else push_word(2'($urandom_range(1, 2)), p, 16'($urandom),
                     24'($urandom_range(0, 24'h00FFFF) >> $urandom_range(0, 6)));
    end
    drain();
  endtask

  initial begin
    reset_mmu_model();
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 0;
    // directed: extremes, every command, duplicates, unknown, suspension
    push_word(cpr_pkg::CMD_READ, 0, 0, 0);
    push_word(cpr_pkg::CMD_CREATE, 0, 16'hFFFF, 0);
    push_word(cpr_pkg::CMD_CREATE, 0, 5, 0);
    push_word(cpr_pkg::CMD_CREATE, 7, 0, 24'hFFFFFF);
    push_word(cpr_pkg::CMD_CREATE, 1, 9, 0);
    push_word(cpr_pkg::CMD_READ, 0, 0, 0);
    push_word(cpr_pkg::CMD_WRITE, 0, 0, 24'h0003FF);
    push_word(cpr_pkg::CMD_READ, 0, 0, 24'h00FFFF);
    push_word(cpr_pkg::CMD_WRITE, 1, 0, 24'h001000);
    push_word(cpr_pkg::CMD_READ, 1, 0, 24'h003FFF);
    push_word(cpr_pkg::CMD_NONE, 1, 16'hFFFF, 24'hFFFFFF);
    push_word(cpr_pkg::CMD_READ, 7, 0, 0);
    push_word(cpr_pkg::CMD_WRITE, 0, 0, 24'hFFFFFF);
    push_word(cpr_pkg::CMD_READ, 0, 0, 0);
    push_word(cpr_pkg::CMD_CREATE, 0, 64, 0);
    drain();
    write_reg(cpr_pkg::CFG_ACTIVE_FRAMES, 2);
    write_reg(cpr_pkg::CFG_PAGE_KB, 1);
    write_reg(cpr_pkg::CFG_ADDR_BITS, 8);
    random_phase(300);
    write_reg(cpr_pkg::CFG_ACTIVE_FRAMES, 0);
    write_reg(cpr_pkg::CFG_PAGE_KB, 0);
    write_reg(cpr_pkg::CFG_ADDR_BITS, 1);
    random_phase(200);
    write_reg(cpr_pkg::CFG_ACTIVE_FRAMES, 31);
    write_reg(cpr_pkg::CFG_PAGE_KB, 11'h7FF);
    write_reg(cpr_pkg::CFG_ADDR_BITS, 6'h3F);
    random_phase(200);
    write_reg(cpr_pkg::CFG_ACTIVE_FRAMES, 5);
    write_reg(cpr_pkg::CFG_PAGE_KB, 2);
    write_reg(cpr_pkg::CFG_ADDR_BITS, 32);
    random_phase(400);
    write_reg(cpr_pkg::CFG_ACTIVE_FRAMES, 16);
    write_reg(cpr_pkg::CFG_PAGE_KB, 4);
    write_reg(cpr_pkg::CFG_ADDR_BITS, 16);
    random_phase(435);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+sv
sv/cpr_pkg.sv
sv/cpr_ctrl.sv
sv/cpr_dp.sv
sv/clock_page_replacement_mmu_core.sv
bench/tb_clock_page_replacement_mmu_core.sv
